// File: hdl/scancode_to_char_with_repeat_top_assert.svh
// Assertion macros shared by the scancode translator top level.
`ifndef SCANCODE_TO_CHAR_WITH_REPEAT_TOP_ASSERT_SVH
`define SCANCODE_TO_CHAR_WITH_REPEAT_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SCTC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define SCTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/sctc_pkg.sv
// Types, constants and lookup functions of the scancode translator.
`timescale 1ns / 1ps
`default_nettype none
package sctc_pkg;

  // Payload of an input transfer.
  typedef struct packed {
    logic       cmd;
    logic [7:0] scan_byte;
  } sctc_in_t;

  // Payload of an output transfer.
  typedef struct packed {
    logic [6:0] character;
    logic       last_of_run;
    logic       is_repeat;
  } sctc_out_t;

  // Classified work item handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_PREFIX,
    OP_KEY
  } sctc_op_e;

  typedef struct packed {
    sctc_op_e   op;
    logic [7:0] scan_byte;
  } sctc_item_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK_DEC,
    ST_TICK_SCAN,
    ST_EMIT
  } sctc_state_e;

  // Configuration write request and current register values.
  typedef struct packed {
    logic        en;
    logic [1:0]  idx;
    logic [15:0] data;
  } sctc_cfg_wr_t;

  typedef struct packed {
    logic [15:0] initial_delay;
    logic [15:0] repeat_interval;
    logic        multi_key_repeat;
  } sctc_cfg_t;

  // Result of translating one key.
  typedef struct packed {
    logic [1:0] n;
    logic       arrow;
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
  } sctc_xlat_t;

  // Register indexes.
  localparam logic [1:0] REG_INIT_DELAY = 2'd0;
  localparam logic [1:0] REG_REPEAT_INT = 2'd1;
  localparam logic [1:0] REG_MULTI_KEY  = 2'd2;

  // Scancodes.
  localparam logic [7:0] SC_PREFIX = 8'hE0;
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_ENTER  = 7'h1C;
  localparam logic [6:0] SC_UP     = 7'h48;
  localparam logic [6:0] SC_DOWN   = 7'h50;
  localparam logic [6:0] SC_LEFT   = 7'h4B;
  localparam logic [6:0] SC_RIGHT  = 7'h4D;

  // Characters.
  localparam logic [6:0] CH_ESC     = 7'h1B;
  localparam logic [6:0] CH_BRACKET = 7'h5B;
  localparam logic [6:0] CH_NEWLINE = 7'h0A;
  localparam logic [6:0] CTRL_MASK  = 7'h1F;

  // Modifier flag bit positions.
  localparam int unsigned MOD_LSHIFT = 0;
  localparam int unsigned MOD_RSHIFT = 1;
  localparam int unsigned MOD_CAPS   = 2;
  localparam int unsigned MOD_LCTRL  = 3;
  localparam int unsigned MOD_RCTRL  = 4;

  // Unshifted key map; codes without a character give zero.
  function automatic logic [6:0] plain_key(logic [6:0] code);
    logic [6:0] k;
    case (code)
      7'd1:  k = 7'h1B;
      7'd2:  k = 7'h31;
      7'd3:  k = 7'h32;
      7'd4:  k = 7'h33;
      7'd5:  k = 7'h34;
      7'd6:  k = 7'h35;
      7'd7:  k = 7'h36;
      7'd8:  k = 7'h37;
      7'd9:  k = 7'h38;
      7'd10: k = 7'h39;
      7'd11: k = 7'h30;
      7'd12: k = 7'h2D;
      7'd13: k = 7'h3D;
      7'd14: k = 7'h08;
      7'd15: k = 7'h09;
      7'd16: k = 7'h71;
      7'd17: k = 7'h77;
      7'd18: k = 7'h65;
      7'd19: k = 7'h72;
      7'd20: k = 7'h74;
      7'd21: k = 7'h79;
      7'd22: k = 7'h75;
      7'd23: k = 7'h69;
      7'd24: k = 7'h6F;
      7'd25: k = 7'h70;
      7'd26: k = 7'h5B;
      7'd27: k = 7'h5D;
      7'd28: k = 7'h0A;
      7'd30: k = 7'h61;
      7'd31: k = 7'h73;
      7'd32: k = 7'h64;
      7'd33: k = 7'h66;
      7'd34: k = 7'h67;
      7'd35: k = 7'h68;
      7'd36: k = 7'h6A;
      7'd37: k = 7'h6B;
      7'd38: k = 7'h6C;
      7'd39: k = 7'h3B;
      7'd40: k = 7'h27;
      7'd41: k = 7'h60;
      7'd43: k = 7'h5C;
      7'd44: k = 7'h7A;
      7'd45: k = 7'h78;
      7'd46: k = 7'h63;
      7'd47: k = 7'h76;
      7'd48: k = 7'h62;
      7'd49: k = 7'h6E;
      7'd50: k = 7'h6D;
      7'd51: k = 7'h2C;
      7'd52: k = 7'h2E;
      7'd53: k = 7'h2F;
      7'd55: k = 7'h2A;
      7'd57: k = 7'h20;
      default: k = 7'h00;
    endcase
    return k;
  endfunction

  // Shifted key map.
  function automatic logic [6:0] shifted_key(logic [6:0] code);
    logic [6:0] k;
    case (code)
      7'd1:  k = 7'h1B;
      7'd2:  k = 7'h21;
      7'd3:  k = 7'h40;
      7'd4:  k = 7'h23;
      7'd5:  k = 7'h24;
      7'd6:  k = 7'h25;
      7'd7:  k = 7'h5E;
      7'd8:  k = 7'h26;
      7'd9:  k = 7'h2A;
      7'd10: k = 7'h28;
      7'd11: k = 7'h29;
      7'd12: k = 7'h5F;
      7'd13: k = 7'h2B;
      7'd14: k = 7'h08;
      7'd15: k = 7'h09;
      7'd16: k = 7'h51;
      7'd17: k = 7'h57;
      7'd18: k = 7'h45;
      7'd19: k = 7'h52;
      7'd20: k = 7'h54;
      7'd21: k = 7'h59;
      7'd22: k = 7'h55;
      7'd23: k = 7'h49;
      7'd24: k = 7'h4F;
      7'd25: k = 7'h50;
      7'd26: k = 7'h7B;
      7'd27: k = 7'h7D;
      7'd28: k = 7'h0A;
      7'd30: k = 7'h41;
      7'd31: k = 7'h53;
      7'd32: k = 7'h44;
      7'd33: k = 7'h46;
      7'd34: k = 7'h47;
      7'd35: k = 7'h48;
      7'd36: k = 7'h4A;
      7'd37: k = 7'h4B;
      7'd38: k = 7'h4C;
      7'd39: k = 7'h3A;
      7'd40: k = 7'h22;
      7'd41: k = 7'h7E;
      7'd43: k = 7'h7C;
      7'd44: k = 7'h5A;
      7'd45: k = 7'h58;
      7'd46: k = 7'h43;
      7'd47: k = 7'h56;
      7'd48: k = 7'h42;
      7'd49: k = 7'h4E;
      7'd50: k = 7'h4D;
      7'd51: k = 7'h3C;
      7'd52: k = 7'h3E;
      7'd53: k = 7'h3F;
      7'd55: k = 7'h2A;
      7'd57: k = 7'h20;
      default: k = 7'h00;
    endcase
    return k;
  endfunction

  // Translate one key under the given modifiers. The held-key check is
  // left to the caller; extended arrows are flagged because they skip it.
  function automatic sctc_xlat_t xlate(logic [6:0] code, logic ext, logic kp,
                                       logic [4:0] mods);
    sctc_xlat_t r;
    logic [6:0] base;
    logic [6:0] sh;
    logic [6:0] ch;
    logic       shift;
    logic       ctrl;
    logic       caps;
    r     = '0;
    base  = plain_key(code);
    sh    = shifted_key(code);
    shift = mods[MOD_LSHIFT] | mods[MOD_RSHIFT];
    ctrl  = mods[MOD_LCTRL] | mods[MOD_RCTRL];
    caps  = mods[MOD_CAPS];
    ch    = base;
    if (ext && (code == SC_UP || code == SC_DOWN || code == SC_LEFT || code == SC_RIGHT)) begin
      r.n     = 2'd3;
      r.arrow = 1'b1;
      r.c0    = CH_ESC;
      r.c1    = CH_BRACKET;
      case (code)
        SC_UP:   r.c2 = 7'h41;
        SC_DOWN: r.c2 = 7'h42;
        SC_LEFT: r.c2 = 7'h44;
        default: r.c2 = 7'h43;
      endcase
    end else if (base != 7'h00) begin
      if (base inside {[7'h61:7'h7A]}) begin
        if (shift != caps) ch = sh;
      end else if (kp) begin
        ch = CH_NEWLINE;
      end else if (shift && sh != 7'h00) begin
        ch = sh;
      end
      if (ctrl) begin
        if (ch inside {[7'h61:7'h7A], [7'h41:7'h5A]}) begin
          r.n  = 2'd1;
          r.c0 = ch & CTRL_MASK;
        end
      end else begin
        r.n  = 2'd1;
        r.c0 = ch;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sctc_front.sv
// Front end: takes input transfers, classifies them and queues them.
`timescale 1ns / 1ps
`default_nettype none
module sctc_front import sctc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  sctc_in_t   in_data_i,
  output logic       item_valid_o,
  input  logic       item_pop_i,
  output sctc_item_t item_o
);

  sctc_item_t mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  sctc_item_t cls;

  // Classify the incoming transfer.
  always_comb begin
    cls.scan_byte = in_data_i.scan_byte;
    if (in_data_i.cmd) begin
      cls.op = OP_TICK;
    end else if (in_data_i.scan_byte == SC_PREFIX) begin
      cls.op = OP_PREFIX;
    end else begin
      cls.op = OP_KEY;
    end
  end

  // Two-entry queue pointers and fill count.
  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && (cnt_q != 2'd0);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

// File: hdl/sctc_back.sv
// Back end: keyboard state, repeat slots, translation and the output register.
`timescale 1ns / 1ps
`default_nettype none
module sctc_back import sctc_pkg::*; #(
  parameter int unsigned REPEAT_SLOTS = 8,
  parameter int unsigned DELAY_WIDTH  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  sctc_cfg_wr_t cfg_wr_i,
  output sctc_cfg_t    cfg_o,
  input  logic         item_valid_i,
  input  sctc_item_t   item_i,
  output logic         item_pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output sctc_out_t    out_data_o
);

  localparam int unsigned SW = (REPEAT_SLOTS > 1) ? $clog2(REPEAT_SLOTS) : 1;
  localparam logic [SW:0] NSLOT = (SW + 1)'(REPEAT_SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(REPEAT_SLOTS - 1);
  localparam logic [15:0] DMAX = 16'((64'd1 << DELAY_WIDTH) - 64'd1);

  // Delays are never zero and never exceed the countdown range.
  function automatic logic [15:0] clamp_delay(logic [15:0] v);
    logic [15:0] r;
    if (v == 16'd0) begin
      r = 16'd1;
    end else if (v > DMAX) begin
      r = DMAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] wrap_idx(logic [SW:0] s);
    logic [SW-1:0] r;
    if (s >= NSLOT) begin
      r = SW'(s - NSLOT);
    end else begin
      r = SW'(s);
    end
    return r;
  endfunction

  sctc_state_e state_q, state_d;
  logic [15:0] init_q, init_d;
  logic [15:0] intv_q, intv_d;
  logic        multi_q, multi_d;
  logic [4:0]  mods_q, mods_d;
  logic        prefix_q, prefix_d;
  logic [127:0] held_q, held_d;
  logic [REPEAT_SLOTS-1:0] act_q, act_d;
  logic [REPEAT_SLOTS-1:0] ext_q, ext_d;
  logic [REPEAT_SLOTS-1:0] kp_q, kp_d;
  logic [REPEAT_SLOTS-1:0] wait_q, wait_d;
  logic [6:0] code_q [REPEAT_SLOTS];
  logic [6:0] code_d [REPEAT_SLOTS];
  logic [DELAY_WIDTH-1:0] cnt_q [REPEAT_SLOTS];
  logic [DELAY_WIDTH-1:0] cnt_d [REPEAT_SLOTS];
  logic [SW-1:0] ptr_q, ptr_d;
  logic [SW-1:0] scan_q, scan_d;
  logic [2:0][6:0] buf_q, buf_d;
  logic [1:0]  n_q, n_d;
  logic [1:0]  k_q, k_d;
  logic        rep_q, rep_d;
  logic        out_valid_q, out_valid_d;
  sctc_out_t   out_q, out_d;

  // Scratch values of the combinational block.
  logic        out_free;
  logic [15:0] new_init;
  logic [15:0] new_intv;
  logic [6:0]  code;
  logic        rel;
  logic        ext;
  logic        kp;
  logic        emit;
  logic        found;
  logic [REPEAT_SLOTS-1:0] avail;
  logic [SW-1:0] pick;
  logic [SW-1:0] idx;
  sctc_xlat_t  xk;
  sctc_xlat_t  xs;

  assign cfg_o.initial_delay    = init_q;
  assign cfg_o.repeat_interval  = intv_q;
  assign cfg_o.multi_key_repeat = multi_q;
  assign out_valid_o            = out_valid_q;
  assign out_data_o             = out_q;

  assign code = item_i.scan_byte[6:0];
  assign rel  = item_i.scan_byte[7];
  assign ext  = prefix_q;
  assign kp   = prefix_q && (code == SC_ENTER);
  assign xk   = xlate(code, ext, kp, mods_q);
  assign idx  = wrap_idx({1'b0, ptr_q} + {1'b0, scan_q});
  assign xs   = xlate(code_q[idx], ext_q[idx], kp_q[idx], mods_q);

  // Next state of the sequencer and of all the state it updates.
  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    intv_d      = intv_q;
    multi_d     = multi_q;
    mods_d      = mods_q;
    prefix_d    = prefix_q;
    held_d      = held_q;
    act_d       = act_q;
    ext_d       = ext_q;
    kp_d        = kp_q;
    wait_d      = wait_q;
    code_d      = code_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    scan_d      = scan_q;
    buf_d       = buf_q;
    n_d         = n_q;
    k_d         = k_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    item_pop_o  = 1'b0;
    new_init    = init_q;
    new_intv    = intv_q;
    emit        = 1'b0;
    found       = 1'b0;
    avail       = '0;
    pick        = '0;

    out_free = !out_valid_q || !out_stall_i;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Register writes; a delay change reloads every active countdown.
    if (cfg_wr_i.en) begin
      case (cfg_wr_i.idx)
        REG_INIT_DELAY, REG_REPEAT_INT: begin
          if (cfg_wr_i.idx == REG_INIT_DELAY) begin
            new_init = clamp_delay(cfg_wr_i.data);
          end else begin
            new_intv = clamp_delay(cfg_wr_i.data);
          end
          init_d = new_init;
          intv_d = new_intv;
          for (int i = 0; i < REPEAT_SLOTS; i++) begin
            if (act_q[i]) begin
              cnt_d[i] = wait_q[i] ? DELAY_WIDTH'(new_init) : DELAY_WIDTH'(new_intv);
            end
          end
        end
        REG_MULTI_KEY: begin
          if (cfg_wr_i.data[0] != multi_q) begin
            multi_d = cfg_wr_i.data[0];
            act_d   = '0;
            ptr_d   = '0;
          end
        end
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          case (item_i.op)
            OP_TICK: begin
              state_d = ST_TICK_DEC;
            end
            OP_PREFIX: begin
              prefix_d = 1'b1;
            end
            OP_KEY: begin
              prefix_d = 1'b0;
              if (code == SC_LSHIFT || code == SC_RSHIFT) begin
                if (code == SC_LSHIFT) begin
                  mods_d[MOD_LSHIFT] = !rel;
                end else begin
                  mods_d[MOD_RSHIFT] = !rel;
                end
                held_d[code] = !rel;
              end else if (code == SC_CAPS && !rel) begin
                mods_d[MOD_CAPS] = !mods_q[MOD_CAPS];
              end else if (code == SC_CTRL) begin
                if (ext) begin
                  mods_d[MOD_RCTRL] = !rel;
                end else begin
                  mods_d[MOD_LCTRL] = !rel;
                  held_d[code]      = !rel;
                end
              end else if (rel) begin
                // Release: free the key and stop its first matching slot.
                held_d[code] = 1'b0;
                for (int i = 0; i < REPEAT_SLOTS; i++) begin
                  if (!found && act_q[i] && code_q[i] == code && ext_q[i] == ext) begin
                    found    = 1'b1;
                    act_d[i] = 1'b0;
                  end
                end
              end else begin
                // Make: arrows bypass the held-key check.
                if (xk.arrow) begin
                  emit = 1'b1;
                end else if (!held_q[code]) begin
                  held_d[code] = 1'b1;
                  emit         = (xk.n != 2'd0);
                end
                if (emit) begin
                  // Start repeating: reuse a matching slot, else the first free one.
                  avail = multi_q ? act_q : '0;
                  if (!multi_q) begin
                    act_d = '0;
                    ptr_d = '0;
                  end
                  for (int i = 0; i < REPEAT_SLOTS; i++) begin
                    if (!found && avail[i] && code_q[i] == code && ext_q[i] == ext) begin
                      found = 1'b1;
                      pick  = SW'(i);
                    end
                  end
                  for (int i = 0; i < REPEAT_SLOTS; i++) begin
                    if (!found && !avail[i]) begin
                      found = 1'b1;
                      pick  = SW'(i);
                    end
                  end
                  if (found) begin
                    act_d[pick]  = 1'b1;
                    code_d[pick] = code;
                    ext_d[pick]  = ext;
                    kp_d[pick]   = kp;
                    wait_d[pick] = 1'b1;
                    cnt_d[pick]  = DELAY_WIDTH'(init_q);
                  end
                  buf_d   = {xk.c2, xk.c1, xk.c0};
                  n_d     = xk.n;
                  k_d     = 2'd0;
                  rep_d   = 1'b0;
                  state_d = ST_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // Count every active slot down by one, saturating at zero.
      ST_TICK_DEC: begin
        for (int i = 0; i < REPEAT_SLOTS; i++) begin
          if (act_q[i] && cnt_q[i] != '0) begin
            cnt_d[i] = cnt_q[i] - DELAY_WIDTH'(1);
          end
        end
        scan_d  = '0;
        state_d = ST_TICK_SCAN;
      end

      // Visit one slot a cycle from the rotating pointer; the first due one with characters fires.
      ST_TICK_SCAN: begin
        if (act_q[idx] && cnt_q[idx] == '0) begin
          if (xs.n == 2'd0) begin
            act_d[idx] = 1'b0;
          end else begin
            emit        = 1'b1;
            wait_d[idx] = 1'b0;
            cnt_d[idx]  = DELAY_WIDTH'(intv_q);
            ptr_d       = wrap_idx({1'b0, idx} + (SW + 1)'(1));
            buf_d       = {xs.c2, xs.c1, xs.c0};
            n_d         = xs.n;
            k_d         = 2'd0;
            rep_d       = 1'b1;
            state_d     = ST_EMIT;
          end
        end
        if (!emit) begin
          if (scan_q == LAST_SLOT) begin
            state_d = ST_IDLE;
          end else begin
            scan_d = scan_q + SW'(1);
          end
        end
      end

      // Hand the run to the output register one character at a time.
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.character   = buf_q[k_q];
          out_d.last_of_run = (k_q == n_q - 2'd1);
          out_d.is_repeat   = rep_q;
          if (k_q == n_q - 2'd1) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      init_q      <= 16'd50;
      intv_q      <= 16'd20;
      multi_q     <= 1'b0;
      mods_q      <= '0;
      prefix_q    <= 1'b0;
      held_q      <= '0;
      act_q       <= '0;
      ptr_q       <= '0;
      scan_q      <= '0;
      k_q         <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      intv_q      <= intv_d;
      multi_q     <= multi_d;
      mods_q      <= mods_d;
      prefix_q    <= prefix_d;
      held_q      <= held_d;
      act_q       <= act_d;
      ptr_q       <= ptr_d;
      scan_q      <= scan_d;
      k_q         <= k_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Slot contents, run buffer and output payload.
  always_ff @(posedge clk_i) begin
    ext_q  <= ext_d;
    kp_q   <= kp_d;
    wait_q <= wait_d;
    code_q <= code_d;
    cnt_q  <= cnt_d;
    buf_q  <= buf_d;
    rep_q  <= rep_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

// File: hdl/scancode_to_char_with_repeat_top.sv
// Top level of the set-1 scancode to ASCII translator with auto-repeat.
`timescale 1ns / 1ps
`default_nettype none
// Takes scancode bytes and timer ticks and returns ASCII characters, three
// for an extended arrow key. A two-entry queue takes input transfers while
// the back end works. A scancode byte is taken from the queue, then the back
// end emits the characters it produces one at a time. A tick is taken from the
// queue, the repeat slots are counted down, then the slots are visited in turn
// while looking for the first due slot (at most REPEAT_SLOTS), then its
// characters are emitted; that slot scan sets the worst case for a tick when
// the output is never stalled.
// A finished character waits in the output register without blocking the
// queue. Registers: 0x0 initial delay, 0x4 repeat interval, 0x8 multi-key
// repeat; write them only while the block is idle.
module scancode_to_char_with_repeat_top import sctc_pkg::*; #(
  parameter int unsigned REPEAT_SLOTS = 8,
  parameter int unsigned DELAY_WIDTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sctc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sctc_out_t   out_data_o
);

  sctc_cfg_wr_t cfg_wr;
  sctc_cfg_t    cfg_vals;
  sctc_item_t   item;
  logic         item_valid;
  logic         item_pop;

  // Register port: writes complete in the access cycle.
  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[3:2];
  assign cfg_wr.data = pwdata[15:0];

  always_comb begin
    case (paddr[3:2])
      REG_INIT_DELAY: prdata = {16'd0, cfg_vals.initial_delay};
      REG_REPEAT_INT: prdata = {16'd0, cfg_vals.repeat_interval};
      REG_MULTI_KEY:  prdata = {31'd0, cfg_vals.multi_key_repeat};
      default:        prdata = 32'd0;
    endcase
  end

  sctc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  sctc_back #(
    .REPEAT_SLOTS (REPEAT_SLOTS),
    .DELAY_WIDTH  (DELAY_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_i     (cfg_wr),
    .cfg_o        (cfg_vals),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // Checks.
`include "scancode_to_char_with_repeat_top_assert.svh"

  `SCTC_ASSERT_ALWAYS(a_init_nonzero, cfg_vals.initial_delay != 16'd0, "initial delay is zero")
  `SCTC_ASSERT_ALWAYS(a_intv_nonzero, cfg_vals.repeat_interval != 16'd0, "repeat interval is zero")
  `SCTC_ASSERT_IMP(a_run_prefix, out_valid_o && !out_data_o.last_of_run, out_data_o.character == CH_ESC || out_data_o.character == CH_BRACKET, "bad character inside a run")

endmodule
`default_nettype wire

// File: tb/tb_scancode_to_char_with_repeat_top.sv
// Self-checking testbench of the scancode translator with auto-repeat.
`timescale 1ns / 1ps
module tb_scancode_to_char_with_repeat_top import sctc_pkg::*; ();

  localparam int unsigned NSLOT       = 8;
  localparam int unsigned WATCH_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned HOLD_CYCLES = 300;

  // Key states that the translator model keeps per repeat slot.
  typedef struct {
    bit          active;
    bit [6:0]    code;
    bit          ext;
    bit          kp;
    bit          waiting;
    int unsigned count;
  } slot_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  sctc_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  sctc_out_t   out_data_o;

  scancode_to_char_with_repeat_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Model state.
  int unsigned m_init;
  int unsigned m_intv;
  bit          m_multi;
  bit [4:0]    m_mods;
  bit          m_prefix;
  bit          m_held [128];
  slot_t       m_slot [NSLOT];
  int unsigned m_rot;

  sctc_in_t    pending_items[$];
  sctc_out_t   expected_chars[$];
  int          errors;
  int          idle_mode;
  int          in_pct;
  int          out_pct;
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned n_in;
  int unsigned n_out;
  int unsigned n_rep;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned clamp16(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic bit letter(bit [6:0] c);
    return (c >= 7'h61 && c <= 7'h7A) || (c >= 7'h41 && c <= 7'h5A);
  endfunction

  // Builds the character run of one key; returns its length (0, 1 or 3).
  function automatic int key_run(bit [6:0] code, bit ext, bit kp, bit synth,
                                 ref bit [6:0] run [3]);
    bit [6:0] base;
    bit [6:0] sh;
    bit [6:0] ch;
    bit       shift;
    bit       ctrl;
    bit       caps;
    if (ext && (code == SC_UP || code == SC_DOWN || code == SC_LEFT || code == SC_RIGHT)) begin
      run[0] = CH_ESC;
      run[1] = CH_BRACKET;
      run[2] = (code == SC_UP) ? 7'h41 : (code == SC_DOWN) ? 7'h42 :
               (code == SC_LEFT) ? 7'h44 : 7'h43;
      return 3;
    end
    if (!synth) begin
      if (m_held[code]) return 0;
      m_held[code] = 1'b1;
    end
    shift = m_mods[MOD_LSHIFT] | m_mods[MOD_RSHIFT];
    ctrl  = m_mods[MOD_LCTRL] | m_mods[MOD_RCTRL];
    caps  = m_mods[MOD_CAPS];
    base  = plain_key(code);
    sh    = shifted_key(code);
    if (base == 0) return 0;
    ch = base;
    if (base >= 7'h61 && base <= 7'h7A) begin
      if (shift != caps) ch = (sh != 0) ? sh : base - 7'd32;
    end else if (kp) begin
      ch = CH_NEWLINE;
    end else if (shift && sh != 0) begin
      ch = sh;
    end
    if (ctrl) begin
      if (!letter(ch)) return 0;
      ch = ch & CTRL_MASK;
    end
    run[0] = ch;
    return 1;
  endfunction

  function automatic void push_run(ref bit [6:0] run [3], input int n, input bit rep);
    sctc_out_t r;
    for (int k = 0; k < n; k++) begin
      r.character   = run[k];
      r.last_of_run = (k == n - 1);
      r.is_repeat   = rep;
      expected_chars.push_back(r);
    end
  endfunction

  function automatic void clear_slots();
    for (int i = 0; i < NSLOT; i++) m_slot[i].active = 1'b0;
    m_rot = 0;
  endfunction

  function automatic void reload_slots();
    for (int i = 0; i < NSLOT; i++)
      if (m_slot[i].active) m_slot[i].count = m_slot[i].waiting ? m_init : m_intv;
  endfunction

  function automatic void model_config(bit [1:0] idx, bit [15:0] v);
    case (idx)
      REG_INIT_DELAY: begin
        m_init = clamp16(v);
        reload_slots();
      end
      REG_REPEAT_INT: begin
        m_intv = clamp16(v);
        reload_slots();
      end
      default: begin
        if (v[0] != m_multi) begin
          m_multi = v[0];
          clear_slots();
        end
      end
    endcase
  endfunction

  function automatic void set_mod(int unsigned b, bit rel);
    m_mods[b] = !rel;
  endfunction

  // Predicts the characters caused by one accepted input transfer.
  function automatic void predict_chars(sctc_in_t it);
    bit [6:0] run [3];
    bit [6:0] code;
    bit       rel;
    bit       ext;
    bit       kp;
    int       n;
    int       pick;
    int unsigned idx;
    if (it.cmd) begin
      for (int i = 0; i < NSLOT; i++)
        if (m_slot[i].active && m_slot[i].count > 0) m_slot[i].count--;
      for (int i = 0; i < NSLOT; i++) begin
        idx = (m_rot + i) % NSLOT;
        if (!m_slot[idx].active || m_slot[idx].count != 0) continue;
        n = key_run(m_slot[idx].code, m_slot[idx].ext, m_slot[idx].kp, 1'b1, run);
        if (n == 0) begin
          m_slot[idx].active = 1'b0;
          continue;
        end
        m_slot[idx].waiting = 1'b0;
        m_slot[idx].count   = m_intv;
        m_rot = (idx + 1) % NSLOT;
        push_run(run, n, 1'b1);
        return;
      end
      return;
    end
    if (it.scan_byte == SC_PREFIX) begin
      m_prefix = 1'b1;
      return;
    end
    rel  = it.scan_byte[7];
    code = it.scan_byte[6:0];
    ext  = 1'b0;
    kp   = 1'b0;
    if (m_prefix) begin
      m_prefix = 1'b0;
      ext = 1'b1;
      kp  = (code == SC_ENTER);
    end
    if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      set_mod(code == SC_LSHIFT ? MOD_LSHIFT : MOD_RSHIFT, rel);
      m_held[code] = !rel;
      return;
    end
    if (code == SC_CAPS && !rel) begin
      m_mods[MOD_CAPS] = !m_mods[MOD_CAPS];
      return;
    end
    if (code == SC_CTRL) begin
      if (ext) begin
        set_mod(MOD_RCTRL, rel);
      end else begin
        set_mod(MOD_LCTRL, rel);
        m_held[code] = !rel;
      end
      return;
    end
    if (rel) begin
      m_held[code] = 1'b0;
      for (int i = 0; i < NSLOT; i++)
        if (m_slot[i].active && m_slot[i].code == code && m_slot[i].ext == ext) begin
          m_slot[i].active = 1'b0;
          break;
        end
      return;
    end
    n = key_run(code, ext, kp, 1'b0, run);
    if (n == 0) return;
    // Start or restart auto-repeat of this key.
    if (!m_multi) clear_slots();
    pick = -1;
    for (int i = 0; i < NSLOT; i++)
      if (pick < 0 && m_slot[i].active && m_slot[i].code == code && m_slot[i].ext == ext)
        pick = i;
    for (int i = 0; i < NSLOT; i++)
      if (pick < 0 && !m_slot[i].active) pick = i;
    if (pick >= 0) begin
      m_slot[pick].active  = 1'b1;
      m_slot[pick].code    = code;
      m_slot[pick].ext     = ext;
      m_slot[pick].kp      = kp;
      m_slot[pick].waiting = 1'b1;
      m_slot[pick].count   = m_init;
    end
    push_run(run, n, 1'b0);
  endfunction

  // Driver: offers queued items, holding a stalled payload steady.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_chars(in_data_i);
        n_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= in_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here once it has been requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each output transfer against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    sctc_out_t exp_c;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (expected_chars.size() == 0) begin
          $error("unexpected output transfer: character %h", out_data_o.character);
          errors++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (exp_c.is_repeat) n_rep++;
          if (out_data_o.character !== exp_c.character) begin
            $error("character: expected %h, actual %h", exp_c.character, out_data_o.character);
            errors++;
          end
          if (out_data_o.last_of_run !== exp_c.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", exp_c.last_of_run,
                   out_data_o.last_of_run);
            errors++;
          end
          if (out_data_o.is_repeat !== exp_c.is_repeat) begin
            $error("is_repeat: expected %b, actual %b", exp_c.is_repeat, out_data_o.is_repeat);
            errors++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < out_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni || psel)
      quiet_cycles <= 0;
    else if (pending_items.size() > 0 || expected_chars.size() > 0 || in_valid_i)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(bit [1:0] idx, bit [15:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_config(idx, v);
  endtask

  // Waits until everything queued has gone through and the block is quiet.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_chars.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic add_item(bit c, bit [7:0] b);
    sctc_in_t it;
    it.cmd       = c;
    it.scan_byte = b;
    pending_items.push_back(it);
  endtask

  task automatic add_ticks(int n);
    for (int i = 0; i < n; i++) add_item(1'b1, 8'($urandom_range(255)));
  endtask

  // One random phase: mostly key presses, releases and ticks.
  task automatic random_phase(int n);
    bit [7:0] b;
    int       r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        add_item(1'b1, 8'($urandom_range(255)));
      end else if (r < 38) begin
        add_item(1'b0, SC_PREFIX);
        add_item(1'b0, {1'($urandom_range(1)), 7'($urandom_range(1) ?
                 SC_UP + 7'($urandom_range(1)) * 8 : $urandom_range(127))});
      end else if (r < 48) begin
        b = {1'($urandom_range(1)),
             7'($urandom_range(3) == 0 ? SC_CTRL : ($urandom_range(1) ? SC_LSHIFT : SC_CAPS))};
        add_item(1'b0, b);
      end else if (r < 92) begin
        add_item(1'b0, {$urandom_range(2) == 0, 7'($urandom_range(1, 57))});
      end else begin
        add_item(1'b0, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_pct = 17; out_pct = 54; hold_req = 1'b0;
    errors = 0; n_in = 0; n_out = 0; n_rep = 0; quiet_cycles = 0;
    m_init = 50; m_intv = 20; m_multi = 1'b0; m_mods = '0; m_prefix = 1'b0; m_rot = 0;
    foreach (m_held[i]) m_held[i] = 1'b0;
    foreach (m_slot[i]) m_slot[i] = '{0, 0, 0, 0, 0, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: short delays, keys with shift, caps and ctrl, arrows, keypad enter.
    reg_write(REG_INIT_DELAY, 16'd0);
    reg_write(REG_REPEAT_INT, 16'd2);
    add_item(1'b0, 8'h1E); add_ticks(3);
    add_item(1'b0, 8'h1E);                       // held key gives nothing
    add_item(1'b0, 8'h9E);
    add_item(1'b0, {1'b0, SC_LSHIFT}); add_item(1'b0, 8'h02); add_item(1'b0, 8'hAA);
    add_item(1'b0, {1'b0, SC_CAPS}); add_item(1'b0, 8'h10); add_item(1'b0, 8'h90);
    add_item(1'b0, {1'b0, SC_CAPS});
    add_item(1'b0, {1'b0, SC_CTRL}); add_item(1'b0, 8'h2E); add_item(1'b0, 8'h03);
    add_item(1'b0, 8'h9D);
    add_item(1'b0, SC_PREFIX); add_item(1'b0, SC_PREFIX); add_item(1'b0, {1'b0, SC_UP});
    add_ticks(2);
    add_item(1'b0, SC_PREFIX); add_item(1'b0, {1'b0, SC_ENTER}); add_item(1'b0, 8'hFF);
    add_item(1'b0, 8'h00);
    drain();

    // Multi-key mode with extreme delays, then the receiver holds off.
    reg_write(REG_MULTI_KEY, 16'd1);
    reg_write(REG_INIT_DELAY, 16'hFFFF);
    reg_write(REG_REPEAT_INT, 16'hFFFF);
    reg_write(REG_INIT_DELAY, 16'd1);
    reg_write(REG_REPEAT_INT, 16'd1);
    hold_req = 1'b1;
    for (int i = 0; i < 10; i++) add_item(1'b0, 8'(16 + i));
    add_ticks(12);
    wait (hold_done && hold_left == 0);
    random_phase(52);
    drain();

    // The other way round, back in single-slot mode.
    in_pct = 54; out_pct = 17;
    reg_write(REG_MULTI_KEY, 16'd0);
    reg_write(REG_INIT_DELAY, 16'd3);
    reg_write(REG_REPEAT_INT, 16'd2);
    random_phase(52);
    drain();

    // No idling, multi-key again.
    in_pct = 0; out_pct = 0;
    reg_write(REG_MULTI_KEY, 16'd1);
    reg_write(REG_INIT_DELAY, 16'd2);
    reg_write(REG_REPEAT_INT, 16'd1);
    random_phase(52);
    drain();

    $display("Covered %0d input and %0d output transfers, %0d of them repeats,", n_in, n_out,
             n_rep);
    $display("over single-slot and multi-key modes with several delay settings.");
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
